// ===== rtl/core/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared widths, constants, codes and helper functions of the steerable band
// mask generator.
// ----------------------------------------------------------------------------
package sbm_pkg;

  // default values of the top level parameters
  localparam int MAX_DIM_DEF       = 4096;
  localparam int CORDIC_STAGES_DEF = 16;

  // field and register widths
  localparam int IDX_W     = 12;
  localparam int SIZE_W    = 13;
  localparam int LEVEL_W   = 4;
  localparam int ORIENT_W  = 4;
  localparam int COUNT_W   = 5;
  localparam int WEIGHT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;

  // fixed point formats
  localparam int FRAC_W  = 24;                  // fraction bits of fx, fy
  localparam int NUM_W   = SIZE_W + FRAC_W + 1; // dividend and quotient width
  localparam int VEC_W   = NUM_W + 2;           // vectoring x, y width
  localparam int ANG_W   = 27;                  // angle width, pi = 2^24
  localparam int ROT_W   = 33;                  // rotation x, y width, Q30
  localparam int MUL_W   = 20;                  // slice of x for the gain product
  localparam int KQ24_W  = 24;
  localparam int RAD_W   = VEC_W;               // radius width
  localparam int RS_W    = RAD_W + 16;          // scaled radius width
  localparam int TURN_W  = 25;                  // one full turn is 2^25

  localparam logic [KQ24_W-1:0]  K_Q24   = 24'd10188014;
  localparam logic [ROT_W-1:0]   K_Q30   = 33'd652032874;
  localparam logic [ROT_W-1:0]   ONE_Q30 = 33'd1073741824;
  localparam logic [TURN_W-1:0]  ANG_PI  = 25'd16777216;
  localparam logic [TURN_W-1:0]  ANG_HPI = 25'd8388608;
  localparam logic [WEIGHT_W-1:0] W_ONE  = 16'd32768;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS   = 3'd0,
    REG_GRID_COLS   = 3'd1,
    REG_SCALE_LEVEL = 3'd2,
    REG_BAND_ORIENT = 3'd3,
    REG_ORIENT_CNT  = 3'd4
  } cfg_reg_e;

  // arctangent table, binary radians with pi = 2^24
  function automatic logic [ANG_W-1:0] atan_of(input int k);
    logic [ANG_W-1:0] a;
    case (k)
      0:       a = 27'd4194304;
      1:       a = 27'd2476042;
      2:       a = 27'd1308273;
      3:       a = 27'd664100;
      4:       a = 27'd333339;
      5:       a = 27'd166832;
      6:       a = 27'd83436;
      7:       a = 27'd41721;
      8:       a = 27'd20861;
      9:       a = 27'd10430;
      10:      a = 27'd5215;
      11:      a = 27'd2608;
      12:      a = 27'd1304;
      13:      a = 27'd652;
      14:      a = 27'd326;
      15:      a = 27'd163;
      16:      a = 27'd81;
      17:      a = 27'd41;
      18:      a = 27'd20;
      19:      a = 27'd10;
      20:      a = 27'd5;
      21:      a = 27'd3;
      22:      a = 27'd1;
      23:      a = 27'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // (1 + c) / 2 in Q1.15 from a cosine in Q30, negated when folded
  function automatic logic [WEIGHT_W-1:0] raised_cos(input logic signed [ROT_W-1:0] x,
                                                     input logic neg);
    logic signed [ROT_W:0]   c;
    logic signed [ROT_W+1:0] s;
    logic signed [ROT_W+1:0] w;
    c = neg ? -{x[ROT_W-1], x} : {x[ROT_W-1], x};
    if (c > $signed({1'b0, ONE_Q30})) begin
      c = $signed({1'b0, ONE_Q30});
    end else if (c < -$signed({1'b0, ONE_Q30})) begin
      c = -$signed({1'b0, ONE_Q30});
    end
    s = $signed({2'b0, ONE_Q30}) + {c[ROT_W], c} + (ROT_W+2)'(32768);
    w = s >>> 16;
    return w[WEIGHT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/sbm_div_cell.sv =====
// ----------------------------------------------------------------------------
// sbm_div_cell
// One restoring division step: brings in the next dividend bit and produces
// one quotient bit, registered for the next cell.
// ----------------------------------------------------------------------------
module sbm_div_cell #(
  parameter int NW = 38,
  parameter int DW = 13,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] div_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] quo_i,
  input  logic [TW-1:0] tag_i,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [DW:0]   trial;
  logic          fits;
  logic [DW-1:0] rem_d;

  // trial subtract of the divisor
  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    fits  = trial >= {1'b0, div_i};
    rem_d = fits ? DW'(trial - {1'b0, div_i}) : trial[DW-1:0];
  end

  // step register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= {num_i[NW-2:0], 1'b0};
      rem_o <= rem_d;
      quo_o <= {quo_i[NW-2:0], fits};
      tag_o <= tag_i;
    end
  end

endmodule

// ===== rtl/core/sbm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// sbm_cordic_cell
// One CORDIC micro-rotation, vectoring or rotation mode, registered for the
// next cell.
// ----------------------------------------------------------------------------
module sbm_cordic_cell #(
  parameter int W      = 40,
  parameter int K      = 0,
  parameter bit VECTOR = 1'b1,
  parameter int TW     = 1
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  input  logic signed [sbm_pkg::ANG_W-1:0] z_i,
  input  logic [TW-1:0]                 tag_i,
  output logic signed [W-1:0]           x_o,
  output logic signed [W-1:0]           y_o,
  output logic signed [sbm_pkg::ANG_W-1:0] z_o,
  output logic [TW-1:0]                 tag_o
);
  import sbm_pkg::*;

  logic signed [W-1:0]     xs;
  logic signed [W-1:0]     ys;
  logic signed [ANG_W-1:0] a;
  logic                    up;

  // direction: drive y to zero or z to zero
  always_comb begin
    xs = x_i >>> K;
    ys = y_i >>> K;
    a  = $signed(atan_of(K));
    up = VECTOR ? !y_i[W-1] : z_i[ANG_W-1];
  end

  // step register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (up) begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + a;
      end else begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - a;
      end
      tag_o <= tag_i;
    end
  end

endmodule

// ===== rtl/core/steerable_band_mask_generator.sv =====
// ----------------------------------------------------------------------------
// steerable_band_mask_generator
// Radial, angular and band weights of one steerable pyramid band for a
// stream of frequency bins.
// ----------------------------------------------------------------------------
// The block takes one bin (row, column) per cycle while the output is not
// stalled and returns one result per bin, in order. The path is a row of
// registered cells: restoring division cells for the normalised frequencies
// and the band direction, a vectoring CORDIC row for radius and angle, a
// sliced gain multiply, and two rotation CORDIC rows for the raised cosines.
// All stages advance together, so a stalled output holds the whole pipe.
// Configuration is taken at any time with cfg_ready_o high; write it only
// while no bin is in flight.
module steerable_band_mask_generator #(
  parameter int MAX_DIM       = sbm_pkg::MAX_DIM_DEF,
  parameter int CORDIC_STAGES = sbm_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // bins in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row_index[11:0], col_index[23:12]
  // weights out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // radial[15:0], angular[31:16], band[47:32]
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbm_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import sbm_pkg::*;

  localparam int CS  = CORDIC_STAGES;
  localparam int LAT = NUM_W + 2 * CS + 7;

  // configuration registers
  logic [SIZE_W-1:0]   grid_rows_q, grid_cols_q;
  logic [LEVEL_W-1:0]  scale_level_q;
  logic [ORIENT_W-1:0] band_orient_q;
  logic [COUNT_W-1:0]  orient_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q   <= SIZE_W'(256);
      grid_cols_q   <= SIZE_W'(256);
      scale_level_q <= '0;
      band_orient_q <= '0;
      orient_cnt_q  <= COUNT_W'(4);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GRID_ROWS:   grid_rows_q   <= cfg_data_i[SIZE_W-1:0];
        REG_GRID_COLS:   grid_cols_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SCALE_LEVEL: scale_level_q <= cfg_data_i[LEVEL_W-1:0];
        REG_BAND_ORIENT: band_orient_q <= cfg_data_i[ORIENT_W-1:0];
        REG_ORIENT_CNT:  orient_cnt_q  <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // derived configuration
  logic [SIZE_W-1:0]  size_r, size_c;
  logic [COUNT_W-1:0] cnt;

  always_comb begin
    size_r = (grid_rows_q < SIZE_W'(2)) ? SIZE_W'(2) :
             (32'(grid_rows_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : grid_rows_q;
    size_c = (grid_cols_q < SIZE_W'(2)) ? SIZE_W'(2) :
             (32'(grid_cols_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : grid_cols_q;
    cnt    = (orient_cnt_q == '0) ? COUNT_W'(1) : orient_cnt_q;
  end

  // pipeline advance and valid chain
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // wrap the index to a signed frequency and form the rounded dividend
  function automatic logic [NUM_W:0] wrap_num(input logic [IDX_W-1:0] idx,
                                              input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] half;
    logic [SIZE_W-1:0] mag;
    logic              neg;
    half = size >> 1;
    neg  = 1'b0;
    mag  = SIZE_W'(idx);
    if (SIZE_W'(idx) >= half) begin
      if (SIZE_W'(idx) < size) begin
        neg = 1'b1;
        mag = size - SIZE_W'(idx);
      end else begin
        mag = SIZE_W'(idx) - size;
      end
    end
    return {neg, NUM_W'({mag, FRAC_W'(0)}) + NUM_W'(half)};
  endfunction

  logic [NUM_W:0]   wrap_r, wrap_c;
  logic [NUM_W-1:0] num_r_q, num_c_q, num_t_q;
  logic             neg_r_q, neg_c_q;

  always_comb begin
    wrap_r = wrap_num(s_axis_tdata[11:0], size_r);
    wrap_c = wrap_num(s_axis_tdata[23:12], size_c);
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en) begin
      num_r_q <= wrap_r[NUM_W-1:0];
      neg_r_q <= wrap_r[NUM_W];
      num_c_q <= wrap_c[NUM_W-1:0];
      neg_c_q <= wrap_c[NUM_W];
      num_t_q <= NUM_W'({band_orient_q, FRAC_W'(0)}) + NUM_W'(cnt >> 1);
    end
  end

  // division rows: fy, fx and band direction
  logic [NUM_W-1:0]   rn [NUM_W+1];
  logic [SIZE_W-1:0]  rr [NUM_W+1];
  logic [NUM_W-1:0]   rq [NUM_W+1];
  logic               rt [NUM_W+1];
  logic [NUM_W-1:0]   cn [NUM_W+1];
  logic [SIZE_W-1:0]  cr [NUM_W+1];
  logic [NUM_W-1:0]   cq [NUM_W+1];
  logic               ct [NUM_W+1];
  logic [NUM_W-1:0]   tn [NUM_W+1];
  logic [COUNT_W-1:0] tr [NUM_W+1];
  logic [NUM_W-1:0]   tq [NUM_W+1];

  assign rn[0] = num_r_q;
  assign rr[0] = '0;
  assign rq[0] = '0;
  assign rt[0] = neg_r_q;
  assign cn[0] = num_c_q;
  assign cr[0] = '0;
  assign cq[0] = '0;
  assign ct[0] = neg_c_q;
  assign tn[0] = num_t_q;
  assign tr[0] = '0;
  assign tq[0] = '0;

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    sbm_div_cell #(.NW(NUM_W), .DW(SIZE_W), .TW(1)) u_row (
      .clk_i, .en_i(en), .div_i(size_r),
      .num_i(rn[k]), .rem_i(rr[k]), .quo_i(rq[k]), .tag_i(rt[k]),
      .num_o(rn[k+1]), .rem_o(rr[k+1]), .quo_o(rq[k+1]), .tag_o(rt[k+1])
    );
    sbm_div_cell #(.NW(NUM_W), .DW(SIZE_W), .TW(1)) u_col (
      .clk_i, .en_i(en), .div_i(size_c),
      .num_i(cn[k]), .rem_i(cr[k]), .quo_i(cq[k]), .tag_i(ct[k]),
      .num_o(cn[k+1]), .rem_o(cr[k+1]), .quo_o(cq[k+1]), .tag_o(ct[k+1])
    );
    sbm_div_cell #(.NW(NUM_W), .DW(COUNT_W), .TW(1)) u_tgt (
      .clk_i, .en_i(en), .div_i(cnt),
      .num_i(tn[k]), .rem_i(tr[k]), .quo_i(tq[k]), .tag_i(1'b0),
      .num_o(tn[k+1]), .rem_o(tr[k+1]), .quo_o(tq[k+1]), .tag_o()
    );
  end

  // sign, zero check and half-turn pre-rotation
  logic signed [VEC_W-1:0] fx, fy;
  logic signed [VEC_W-1:0] vx [CS+1];
  logic signed [VEC_W-1:0] vy [CS+1];
  logic signed [ANG_W-1:0] vz [CS+1];
  logic [TURN_W:0]         vt [CS+1];
  logic signed [VEC_W-1:0] vx0_q, vy0_q;
  logic signed [ANG_W-1:0] vz0_q;
  logic [TURN_W:0]         vt0_q;

  always_comb begin
    fx = ct[NUM_W] ? -$signed({2'b0, cq[NUM_W]}) : $signed({2'b0, cq[NUM_W]});
    fy = rt[NUM_W] ? -$signed({2'b0, rq[NUM_W]}) : $signed({2'b0, rq[NUM_W]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fx < 0) begin
        vx0_q <= -fx;
        vy0_q <= -fy;
        vz0_q <= (fy >= 0) ? $signed(ANG_W'(ANG_PI)) : -$signed(ANG_W'(ANG_PI));
      end else begin
        vx0_q <= fx;
        vy0_q <= fy;
        vz0_q <= '0;
      end
      vt0_q <= {(cq[NUM_W] == '0) && (rq[NUM_W] == '0), tq[NUM_W][TURN_W-1:0]};
    end
  end

  assign vx[0] = vx0_q;
  assign vy[0] = vy0_q;
  assign vz[0] = vz0_q;
  assign vt[0] = vt0_q;

  // vectoring row: radius and angle
  for (genvar k = 0; k < CS; k++) begin : g_vec
    sbm_cordic_cell #(.W(VEC_W), .K(k), .VECTOR(1'b1), .TW(TURN_W+1)) u_cell (
      .clk_i, .en_i(en),
      .x_i(vx[k]), .y_i(vy[k]), .z_i(vz[k]), .tag_i(vt[k]),
      .x_o(vx[k+1]), .y_o(vy[k+1]), .z_o(vz[k+1]), .tag_o(vt[k+1])
    );
  end

  // gain product in two slices, angle difference to the band direction
  logic [MUL_W+KQ24_W-1:0] p_lo_q, p_hi_q;
  logic [TURN_W-1:0]       dif, d_q;
  logic                    zero_m1_q;

  always_comb begin
    dif = (vt[CS][TURN_W] ? '0 : vz[CS][TURN_W-1:0]) - vt[CS][TURN_W-1:0];
    if (dif > ANG_PI) begin
      dif = TURN_W'((TURN_W+1)'(1) << TURN_W) - dif;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_lo_q    <= (MUL_W+KQ24_W)'(vx[CS][MUL_W-1:0]) * (MUL_W+KQ24_W)'(K_Q24);
      p_hi_q    <= (MUL_W+KQ24_W)'(vx[CS][VEC_W-1:MUL_W]) * (MUL_W+KQ24_W)'(K_Q24);
      d_q       <= dif;
      zero_m1_q <= vt[CS][TURN_W];
    end
  end

  // radius and scaled angle
  logic [RAD_W+KQ24_W-1:0] rsum;
  logic [RAD_W-1:0]        radius_q;
  logic [TURN_W+COUNT_W-1:0] dn_q;

  assign rsum = ((RAD_W+KQ24_W)'(p_hi_q) << MUL_W) + (RAD_W+KQ24_W)'(p_lo_q)
              + (RAD_W+KQ24_W)'(1 << 23);

  always_ff @(posedge clk_i) begin
    if (en) begin
      radius_q <= zero_m1_q ? '0 : rsum[RAD_W+KQ24_W-1:KQ24_W];
      dn_q     <= (TURN_W+COUNT_W)'(d_q) * (TURN_W+COUNT_W)'(cnt);
    end
  end

  // phases of the two raised cosines
  logic [RS_W-1:0]         rs;
  logic signed [ROT_W-1:0] ax [CS+1];
  logic signed [ROT_W-1:0] ay [CS+1];
  logic signed [ANG_W-1:0] az [CS+1];
  logic [1:0]              at [CS+1];
  logic signed [ROT_W-1:0] bx [CS+1];
  logic signed [ROT_W-1:0] by [CS+1];
  logic signed [ANG_W-1:0] bz [CS+1];
  logic [1:0]              bt [CS+1];
  logic signed [ANG_W-1:0] rad_ph_q, ang_ph_q;
  logic [1:0]              rad_tag_q, ang_tag_q;

  // shift amount one bit wider so that the top level still doubles
  assign rs = RS_W'(radius_q) << ({1'b0, scale_level_q} + (LEVEL_W+1)'(1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_ph_q  <= $signed(ANG_W'(rs[TURN_W-1:0] - ANG_HPI));
      rad_tag_q <= {rs < RS_W'(ANG_HPI), rs >= RS_W'(ANG_PI)};
      ang_ph_q  <= (dn_q > (TURN_W+COUNT_W)'(ANG_HPI))
                 ? $signed(ANG_W'(ANG_PI - dn_q[TURN_W-1:0]))
                 : $signed(ANG_W'(dn_q[TURN_W-1:0]));
      ang_tag_q <= {dn_q > (TURN_W+COUNT_W)'(ANG_HPI),
                    dn_q >= (TURN_W+COUNT_W)'(ANG_PI)};
    end
  end

  assign ax[0] = $signed(K_Q30);
  assign ay[0] = '0;
  assign az[0] = rad_ph_q;
  assign at[0] = rad_tag_q;
  assign bx[0] = $signed(K_Q30);
  assign by[0] = '0;
  assign bz[0] = ang_ph_q;
  assign bt[0] = ang_tag_q;

  // rotation rows: radial and angular cosines
  for (genvar k = 0; k < CS; k++) begin : g_rot
    sbm_cordic_cell #(.W(ROT_W), .K(k), .VECTOR(1'b0), .TW(2)) u_rad (
      .clk_i, .en_i(en),
      .x_i(ax[k]), .y_i(ay[k]), .z_i(az[k]), .tag_i(at[k]),
      .x_o(ax[k+1]), .y_o(ay[k+1]), .z_o(az[k+1]), .tag_o(at[k+1])
    );
    sbm_cordic_cell #(.W(ROT_W), .K(k), .VECTOR(1'b0), .TW(2)) u_ang (
      .clk_i, .en_i(en),
      .x_i(bx[k]), .y_i(by[k]), .z_i(bz[k]), .tag_i(bt[k]),
      .x_o(bx[k+1]), .y_o(by[k+1]), .z_o(bz[k+1]), .tag_o(bt[k+1])
    );
  end

  // radial and angular weights
  logic [WEIGHT_W-1:0] rw_q, aw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rw_q <= at[CS][1] ? W_ONE : at[CS][0] ? '0 : raised_cos(ax[CS], 1'b0);
      aw_q <= bt[CS][0] ? '0 : raised_cos(bx[CS], bt[CS][1]);
    end
  end

  // band product and output register
  logic [2*WEIGHT_W:0] prod;
  logic [WEIGHT_W-1:0] rw_o_q, aw_o_q, bw_o_q;

  assign prod = (2*WEIGHT_W+1)'(rw_q) * (2*WEIGHT_W+1)'(aw_q) + (2*WEIGHT_W+1)'(16384);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rw_o_q <= rw_q;
      aw_o_q <= aw_q;
      bw_o_q <= prod[WEIGHT_W+14:15];
    end
  end

  assign m_axis_tdata = {bw_o_q, aw_o_q, rw_o_q};

  // checks
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rw_o_q <= W_ONE) && (aw_o_q <= W_ONE))
    else $error("weight above one");

  a_band_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (bw_o_q <= rw_o_q) && (bw_o_q <= aw_o_q))
    else $error("band weight above a factor");

  a_band_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (rw_o_q == W_ONE)) |-> (bw_o_q == aw_o_q))
    else $error("band weight differs from angular weight at full radial");

endmodule

// ===== tb/sv/steerable_band_mask_generator_checker.sv =====
// ----------------------------------------------------------------------------
// steerable_band_mask_generator_checker
// Watches the bin, weight and configuration channels, predicts the radial,
// angular and band weights of every bin and compares them in order.
// ----------------------------------------------------------------------------
module steerable_band_mask_generator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [sbm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sbm_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbm_pkg::*;

  localparam longint PI_BRAD = 64'd16777216;
  localparam longint KG24    = 64'd10188014;
  localparam longint KG30    = 64'd652032874;
  localparam longint Q30_ONE = 64'd1073741824;

  typedef struct packed {
    logic [15:0] radial;
    logic [15:0] angular;
    logic [15:0] band;
  } weights_t;

  logic [12:0] rows_q, cols_q;
  logic [3:0]  level_q, orient_q;
  logic [4:0]  count_q;
  weights_t    weight_fifo[$];
  int          mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = weight_fifo.size();

  function automatic longint arc_step(int k);
    longint t[24] = '{4194304, 2476042, 1308273, 664100, 333339, 166832, 83436,
                      41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                      81, 41, 20, 10, 5, 3, 1, 1};
    return t[k];
  endfunction

  function automatic longint size_clip(logic [12:0] n);
    if (n < 2) return 2;
    if (n > 4096) return 4096;
    return longint'(n);
  endfunction

  // signed wrap and rounded division to 24 fraction bits
  function automatic longint bin_freq(logic [11:0] idx, longint sz);
    longint w, m, q;
    w = longint'(idx);
    if (w >= sz / 2) w -= sz;
    m = (w < 0) ? -w : w;
    q = ((m <<< 24) + sz / 2) / sz;
    return (w < 0) ? -q : q;
  endfunction

  // (1 + cos(phase)) / 2 in Q1.15 via rotation cordic
  function automatic logic [15:0] half_cos_weight(longint phase);
    logic   fold;
    longint x, y, z, xs, ys, c, w;
    fold = 0;
    x = KG30;
    y = 0;
    if (phase < 0) phase = 0;
    if (phase > PI_BRAD) phase = PI_BRAD;
    if (phase > PI_BRAD / 2) begin
      fold = 1;
      phase = PI_BRAD - phase;
    end
    z = phase;
    for (int k = 0; k < 16; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arc_step(k);
      end else begin
        x += ys; y -= xs; z += arc_step(k);
      end
    end
    c = fold ? -x : x;
    if (c > Q30_ONE) c = Q30_ONE;
    if (c < -Q30_ONE) c = -Q30_ONE;
    w = (Q30_ONE + c + 32768) >>> 16;
    if (w > 32768) w = 32768;
    return w[15:0];
  endfunction

  function automatic weights_t bin_weights(logic [11:0] row, logic [11:0] col);
    weights_t r;
    longint   fx, fy, x, y, z, xs, ys, radius, theta, rs, n, target, d, dn, bw;
    fx = bin_freq(col, size_clip(cols_q));
    fy = bin_freq(row, size_clip(rows_q));
    x = fx; y = fy; z = 0;
    if (fx == 0 && fy == 0) begin
      radius = 0;
      theta = 0;
    end else begin
      if (x < 0) begin
        z = (y >= 0) ? PI_BRAD : -PI_BRAD;
        x = -x;
        y = -y;
      end
      for (int k = 0; k < 16; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (y >= 0) begin
          x += ys; y -= xs; z += arc_step(k);
        end else begin
          x -= ys; y += xs; z -= arc_step(k);
        end
      end
      radius = (x * KG24 + (64'd1 <<< 23)) >>> 24;
      theta = z;
    end
    rs = radius <<< (level_q + 1);
    if (rs < (64'd1 <<< 23)) r.radial = 16'd32768;
    else if (rs < (64'd1 <<< 24)) r.radial = half_cos_weight(rs - (64'd1 <<< 23));
    else r.radial = 16'd0;
    n = (count_q == 0) ? 1 : longint'(count_q);
    target = ((longint'(orient_q) <<< 24) + n / 2) / n;
    d = (theta - target) & 64'h1FF_FFFF;
    if (d > PI_BRAD) d = 64'h200_0000 - d;
    dn = d * n;
    r.angular = (dn < PI_BRAD) ? half_cos_weight(dn) : 16'd0;
    bw = (longint'(r.radial) * longint'(r.angular) + 16384) >>> 15;
    if (bw > 32768) bw = 32768;
    r.band = bw[15:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    weights_t want, got;
    if (!rst_ni) begin
      rows_q   <= 13'd256;
      cols_q   <= 13'd256;
      level_q  <= '0;
      orient_q <= '0;
      count_q  <= 5'd4;
      weight_fifo.delete();
      mismatches <= 0;
    end else begin
      // register write transfer
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_GRID_ROWS:   rows_q   <= cfg_data_i;
          REG_GRID_COLS:   cols_q   <= cfg_data_i;
          REG_SCALE_LEVEL: level_q  <= cfg_data_i[3:0];
          REG_BAND_ORIENT: orient_q <= cfg_data_i[3:0];
          REG_ORIENT_CNT:  count_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      // bin transfer
      if (s_axis_tvalid && s_axis_tready) begin
        weight_fifo.push_back(bin_weights(s_axis_tdata[11:0], s_axis_tdata[23:12]));
      end
      // weight transfer, radial in the low bits of the bus
      if (m_axis_tvalid && m_axis_tready) begin
        got = weights_t'({m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32]});
        if (weight_fifo.size() == 0) begin
          if (mismatches < 10) $display("unexpected weights %h", m_axis_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = weight_fifo.pop_front();
          if (want != got) begin
            if (mismatches < 10)
              $display("weight mismatch: exp rad %0d ang %0d band %0d, got %0d %0d %0d",
                       want.radial, want.angular, want.band,
                       got.radial, got.angular, got.band);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/steerable_band_mask_generator_tb.sv =====
// ----------------------------------------------------------------------------
// steerable_band_mask_generator_tb
// Drives directed and random frequency bins through several grid, scale and
// orientation settings under random idling and back pressure; the checker
// predicts every weight.
// ----------------------------------------------------------------------------
module steerable_band_mask_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbm_pkg::*;

  localparam int LATENCY   = 100;
  localparam int MAX_CYCLE = 400000;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;    // row_index[11:0], col_index[23:12]
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;    // radial[15:0], angular[31:16], band[47:32]
  logic        cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  int          fail_count, pending;
  int          send_idle_pct, take_idle_pct, hold_cycles;
  int          cycle_count;
  logic [12:0] cur_rows, cur_cols;

  steerable_band_mask_generator u_top (.*);

  steerable_band_mask_generator_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_GRID_ROWS) cur_rows = val;
    if (idx == REG_GRID_COLS) cur_cols = val;
  endtask

  task automatic send_bin(logic [11:0] row, logic [11:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {col, row};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // mostly in-grid indexes, sometimes any value
  task automatic random_bins(int count);
    logic [11:0] r, c;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        r = 12'($urandom);
        c = 12'($urandom);
      end else begin
        r = 12'($urandom_range(cur_rows > 4096 ? 4095 :
                               (cur_rows == 0 ? 0 : cur_rows - 1)));
        c = 12'($urandom_range(cur_cols > 4096 ? 4095 :
                               (cur_cols == 0 ? 0 : cur_cols - 1)));
      end
      send_bin(r, c);
    end
  endtask

  task automatic configure(logic [12:0] r, logic [12:0] c, logic [3:0] lv,
                           logic [3:0] o, logic [4:0] n);
    write_reg(REG_GRID_ROWS, r);
    write_reg(REG_GRID_COLS, c);
    write_reg(REG_SCALE_LEVEL, 13'(lv));
    write_reg(REG_BAND_ORIENT, 13'(o));
    write_reg(REG_ORIENT_CNT, 13'(n));
  endtask

  initial begin
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    cfg_valid_i = 0;
    cfg_index_i = REG_GRID_ROWS;
    cfg_data_i = '0;
    send_idle_pct = 29;
    take_idle_pct = 50;
    hold_cycles = 0;
    cur_rows = 256;
    cur_cols = 256;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed bins at reset settings: zero frequency, edges, axes, diagonals
    send_bin(0, 0);
    send_bin(0, 1);
    send_bin(1, 0);
    send_bin(0, 127);
    send_bin(0, 128);
    send_bin(128, 0);
    send_bin(255, 255);
    send_bin(4095, 4095);
    send_bin(12'hAAA, 12'h555);
    send_bin(12'h555, 12'hAAA);
    send_bin(64, 64);
    send_bin(192, 64);
    send_bin(0, 40);
    send_bin(0, 80);
    drain();

    // grid sizes clipped, orientation beyond count, count zero
    configure(13'd0, 13'd8191, 4'd15, 4'd15, 5'd0);
    send_bin(1, 0);
    send_bin(0, 1);
    send_bin(0, 4095);
    drain();
    configure(13'd4096, 13'd2, 4'd0, 4'd9, 5'd16);
    send_bin(4095, 1);
    send_bin(2048, 0);
    send_bin(3, 0);
    drain();

    // random phase 1
    configure(13'd64, 13'd48, 4'd1, 4'd2, 5'd4);
    random_bins(120);
    drain();
    // long receiver hold-off while bins keep coming
    hold_cycles = 300;
    configure(13'd32, 13'd32, 4'd0, 4'd1, 5'd6);
    random_bins(150);
    drain();

    send_idle_pct = 50;
    take_idle_pct = 29;
    configure(13'd4096, 13'd4096, 4'd3, 4'd7, 5'd8);
    random_bins(100);
    drain();
    configure(13'd2, 13'd3, 4'd2, 4'd0, 5'd1);
    random_bins(40);
    drain();

    send_idle_pct = 0;
    take_idle_pct = 0;
    configure(13'd200, 13'd120, 4'd0, 4'd3, 5'd5);
    random_bins(120);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/sbm_pkg.sv
rtl/core/sbm_div_cell.sv
rtl/core/sbm_cordic_cell.sv
rtl/core/steerable_band_mask_generator.sv
tb/sv/steerable_band_mask_generator_checker.sv
tb/sv/steerable_band_mask_generator_tb.sv
